// ===== hdl/lmr_pkg.sv =====
// lmr_pkg: shared types, constants and microcode for the led matrix row refresh core
// holds the word structs, control word layout, program rom and opcode dispatch
// no dependencies
package lmr_pkg;

    localparam int unsigned ROWS_DEF = 8;
    localparam int unsigned COLS_DEF = 8;

    // program counter width and program entry points
    localparam int unsigned PC_W = 4;
    localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] PC_SET      = 4'd1;
    localparam logic [PC_W-1:0] PC_REF      = 4'd2;
    localparam logic [PC_W-1:0] PC_REF_RD   = 4'd3;
    localparam logic [PC_W-1:0] PC_REF_B    = 4'd4;
    localparam logic [PC_W-1:0] PC_REF_G    = 4'd5;
    localparam logic [PC_W-1:0] PC_REF_R    = 4'd6;
    localparam logic [PC_W-1:0] PC_REF_END  = 4'd7;
    localparam logic [PC_W-1:0] PC_SEL      = 4'd8;
    localparam logic [PC_W-1:0] PC_INIT     = 4'd9;
    localparam logic [PC_W-1:0] PC_INIT_EM  = 4'd10;
    localparam logic [PC_W-1:0] PC_INIT_END = 4'd11;

    localparam logic       KIND_WORD   = 1'b0;
    localparam logic       KIND_CHAN   = 1'b1;
    localparam logic       BANK_BRIGHT = 1'b0;
    localparam logic       BANK_COLOUR = 1'b1;
    localparam logic [3:0] LEN_COLOUR  = 4'd8;
    localparam logic [3:0] LEN_BRIGHT  = 4'd6;
    localparam logic [3:0] LEN_NONE    = 4'd0;
    localparam logic [7:0] BRIGHT_WORD = 8'h3F;
    localparam logic [7:0] LINE_MAX    = 8'd7;

    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_REFRESH = 2'd1,
        OP_SELECT  = 2'd2,
        OP_INIT    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] column_index;
        logic [2:0] row_index;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_in;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] shift_word;
        logic [3:0] word_length;
        logic       bank_select;
        logic       latch_after;
        logic [7:0] channel_mask;
        logic       reset_pulse;
        logic       last_of_run;
    } t_out;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_DISPATCH,
        BR_IF_BAD,
        BR_ROW_MORE,
        BR_WORD_MORE
    } t_br;

    typedef enum logic [2:0] {
        SRC_BLUE,
        SRC_GREEN,
        SRC_RED,
        SRC_BRIGHT,
        SRC_CHAN
    } t_src;

    typedef struct packed {
        t_wait           wait_on;
        t_br             br;
        logic [PC_W-1:0] target;
        logic            take_in;
        logic            mem_wr;
        logic            mem_rd;
        logic            cnt_clr;
        logic            cnt_inc;
        logic            bank_set;
        logic            mask_sel;
        logic            mask_clr;
        logic            emit;
        t_src            src;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        logic  fire;
    } t_issue;

    typedef struct packed {
        logic [1:0] opcode;
        logic       in_valid;
        logic       out_free;
        logic       col_bad;
        logic       row_more;
        logic       word_more;
    } t_status;

    // control store
    function automatic t_ctrl lmr_ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '0;
        case (pc)
            PC_FETCH: begin
                c.wait_on = W_IN;
                c.take_in = 1'b1;
                c.br      = BR_DISPATCH;
            end
            PC_SET: begin
                c.mem_wr = 1'b1;
                c.br     = BR_ALWAYS;
                c.target = PC_FETCH;
            end
            PC_REF: begin
                c.cnt_clr = 1'b1;
                c.br      = BR_IF_BAD;
                c.target  = PC_FETCH;
            end
            PC_REF_RD: begin
                c.mem_rd   = 1'b1;
                c.bank_set = 1'b1;
            end
            PC_REF_B: begin
                c.wait_on = W_OUT;
                c.emit    = 1'b1;
                c.src     = SRC_BLUE;
            end
            PC_REF_G: begin
                c.wait_on = W_OUT;
                c.emit    = 1'b1;
                c.src     = SRC_GREEN;
            end
            PC_REF_R: begin
                c.wait_on = W_OUT;
                c.emit    = 1'b1;
                c.src     = SRC_RED;
                c.cnt_inc = 1'b1;
                c.br      = BR_ROW_MORE;
                c.target  = PC_REF_RD;
            end
            PC_REF_END: begin
                c.br     = BR_ALWAYS;
                c.target = PC_FETCH;
            end
            PC_SEL: begin
                c.wait_on  = W_OUT;
                c.emit     = 1'b1;
                c.src      = SRC_CHAN;
                c.mask_sel = 1'b1;
                c.br       = BR_ALWAYS;
                c.target   = PC_FETCH;
            end
            PC_INIT: begin
                c.mask_clr = 1'b1;
                c.cnt_clr  = 1'b1;
            end
            PC_INIT_EM: begin
                c.wait_on = W_OUT;
                c.emit    = 1'b1;
                c.src     = SRC_BRIGHT;
                c.cnt_inc = 1'b1;
                c.br      = BR_WORD_MORE;
                c.target  = PC_INIT_EM;
            end
            PC_INIT_END: begin
                c.bank_set = 1'b1;
                c.br       = BR_ALWAYS;
                c.target   = PC_FETCH;
            end
            default: begin
                c.br     = BR_ALWAYS;
                c.target = PC_FETCH;
            end
        endcase
        return c;
    endfunction

    function automatic logic [PC_W-1:0] lmr_dispatch(input logic [1:0] op);
        logic [PC_W-1:0] pc;
        case (t_op'(op))
            OP_SET:     pc = PC_SET;
            OP_REFRESH: pc = PC_REF;
            OP_SELECT:  pc = PC_SEL;
            OP_INIT:    pc = PC_INIT;
            default:    pc = PC_FETCH;
        endcase
        return pc;
    endfunction

endpackage

// ===== hdl/led_matrix_row_refresh_core.sv =====
// led_matrix_row_refresh_core: top level, command register, counters and result register
// depends on lmr_pkg, lmr_sequencer and lmr_frame_mem
//
// Usage:
//   Input channel carries one command word (i_in_data) under i_in_valid / o_in_stall.
//   Output channel carries serial words and channel updates (o_out_data) under
//   o_out_valid / i_out_stall. last_of_run marks the final word of a command.
//   A command is taken only when the microprogram sits at its fetch step.
//   Words per command:
//     set pixel       none
//     select line     one channel update
//     refresh column  three words per row, one frame store read per row
//     initialise      3*ROWS brightness words, one per cycle unless the output stalls
//   The run is set by the microprogram loop, which issues one word per step and
//   one frame store read per row. An out-of-range refresh emits no words.
//   A single result register sits on the output, so the next command is taken
//   while the last word of the previous one still waits. When the receiver stalls,
//   the emitting step holds and the word stays unchanged.
//   Reset (synchronous, active low) clears the frame store to black at once through
//   per-pixel valid bits, clears the line mask and bank flag, and empties the output.
module led_matrix_row_refresh_core #(
    parameter int unsigned ROWS    = lmr_pkg::ROWS_DEF,
    parameter int unsigned COLUMNS = lmr_pkg::COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lmr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lmr_pkg::t_out o_out_data
);
    import lmr_pkg::*;

    localparam int unsigned DEPTH = ROWS * COLUMNS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WORDS = ROWS * 3;
    localparam int unsigned CNT_W = $clog2(WORDS);

    t_status          status;
    t_issue           issue;
    t_ctrl            ctrl;
    logic             fire;

    t_in              r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       r_mask;
    logic [7:0]       n_mask;
    logic             r_bank;
    logic             n_bank;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic             col_ok;
    logic             set_ok;
    logic [7:0]       sel_mask;
    logic             row_last;
    logic             word_last;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [23:0]      rd_data;

    assign ctrl = issue.ctrl;
    assign fire = issue.fire;

    assign col_ok    = 32'(r_cmd.column_index) < COLUMNS;
    assign set_ok    = col_ok && (32'(r_cmd.row_index) < ROWS);
    assign row_last  = r_cnt == CNT_W'(ROWS - 1);
    assign word_last = r_cnt == CNT_W'(WORDS - 1);

    // one-hot line select, all off past the eighth line or the last column
    assign sel_mask = (r_cmd.column_index <= LINE_MAX && col_ok)
                    ? (8'd1 << r_cmd.column_index[2:0]) : 8'd0;

    assign wr_addr = AW'(32'(r_cmd.column_index) * ROWS + 32'(r_cmd.row_index));
    assign rd_addr = AW'(32'(r_cmd.column_index) * ROWS + 32'(r_cnt));

    always_comb begin
        status.opcode    = i_in_data.opcode;
        status.in_valid  = i_in_valid;
        status.out_free  = !r_out_valid || !i_out_stall;
        status.col_bad   = !col_ok;
        status.row_more  = !row_last;
        status.word_more = !word_last;
    end

    lmr_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_issue  (issue)
    );

    lmr_frame_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (fire && ctrl.mem_wr && set_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_cmd.red_level, r_cmd.green_level, r_cmd.blue_level}),
        .i_rd_en   (fire && ctrl.mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = ctrl.wait_on != W_IN;

    always_comb begin
        n_cnt  = r_cnt;
        n_mask = r_mask;
        n_bank = r_bank;
        if (fire) begin
            if (ctrl.cnt_clr) begin
                n_cnt = '0;
            end else if (ctrl.cnt_inc) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (ctrl.mask_sel) begin
                n_mask = sel_mask;
            end else if (ctrl.mask_clr) begin
                n_mask = '0;
            end
            if (ctrl.bank_set) begin
                n_bank = BANK_COLOUR;
            end
        end
    end

    // result word assembly
    always_comb begin
        n_out              = '0;
        n_out.result_kind  = KIND_WORD;
        n_out.channel_mask = r_mask;
        case (ctrl.src)
            SRC_BLUE: begin
                n_out.shift_word  = rd_data[7:0];
                n_out.word_length = LEN_COLOUR;
                n_out.bank_select = BANK_COLOUR;
            end
            SRC_GREEN: begin
                n_out.shift_word  = rd_data[15:8];
                n_out.word_length = LEN_COLOUR;
                n_out.bank_select = BANK_COLOUR;
            end
            SRC_RED: begin
                n_out.shift_word  = rd_data[23:16];
                n_out.word_length = LEN_COLOUR;
                n_out.bank_select = BANK_COLOUR;
                n_out.latch_after = row_last;
                n_out.last_of_run = row_last;
            end
            SRC_BRIGHT: begin
                n_out.shift_word  = BRIGHT_WORD;
                n_out.word_length = LEN_BRIGHT;
                n_out.bank_select = BANK_BRIGHT;
                n_out.reset_pulse = r_cnt == '0;
                n_out.last_of_run = word_last;
            end
            SRC_CHAN: begin
                n_out.result_kind  = KIND_CHAN;
                n_out.word_length  = LEN_NONE;
                n_out.bank_select  = r_bank;
                n_out.channel_mask = sel_mask;
                n_out.last_of_run  = 1'b1;
            end
            default: begin
                n_out.word_length = LEN_NONE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire && ctrl.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && ctrl.take_in) begin
            r_cmd <= i_in_data;
        end
        if (fire && ctrl.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_mask      <= '0;
            r_bank      <= BANK_BRIGHT;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_mask      <= n_mask;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/lmr_frame_mem.sv =====
// lmr_frame_mem: pixel frame store, one 24-bit word {red, green, blue} per pixel
// one write port, one registered read port, per-pixel valid bits so unwritten pixels read zero
// depends on nothing outside this file
module lmr_frame_mem #(
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [23:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [23:0]   o_rd_data
);

    logic [23:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [23:0]      r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // a pixel never written since reset reads as black
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/lmr_sequencer.sv =====
// lmr_sequencer: program counter, control store lookup and branch logic
// uses lmr_pkg for the control word layout, rom and dispatch table
module lmr_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lmr_pkg::t_status i_status,
    output lmr_pkg::t_issue  o_issue
);
    import lmr_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            fire;

    assign ctrl = lmr_ucode(r_pc);

    // a step holds until its wait condition is met
    always_comb begin
        case (ctrl.wait_on)
            W_NONE:  fire = 1'b1;
            W_IN:    fire = i_status.in_valid;
            W_OUT:   fire = i_status.out_free;
            default: fire = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (fire) begin
            case (ctrl.br)
                BR_NEXT:      n_pc = r_pc + 1'b1;
                BR_ALWAYS:    n_pc = ctrl.target;
                BR_DISPATCH:  n_pc = lmr_dispatch(i_status.opcode);
                BR_IF_BAD:    n_pc = i_status.col_bad ? ctrl.target : r_pc + 1'b1;
                BR_ROW_MORE:  n_pc = i_status.row_more ? ctrl.target : r_pc + 1'b1;
                BR_WORD_MORE: n_pc = i_status.word_more ? ctrl.target : r_pc + 1'b1;
                default:      n_pc = PC_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        o_issue.ctrl = ctrl;
        o_issue.fire = fire;
    end

endmodule

// ===== hdl/lmr_checker.sv =====
// lmr_checker: port-level checks for led_matrix_row_refresh_core, attached by bind
// depends on lmr_pkg and the top level's ports
module lmr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lmr_pkg::t_out o_out_data
);
    import lmr_pkg::*;

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // no new command is taken while a run is still producing words
    a_no_fetch_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_of_run |-> o_in_stall)
        else $error("command accepted in the middle of a run");

    // latch only on the closing colour word
    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.latch_after |->
            o_out_data.last_of_run && o_out_data.bank_select == BANK_COLOUR)
        else $error("latch on a word that does not end a colour run");

    // init clears the line mask before its brightness words
    a_reset_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.reset_pulse |-> o_out_data.channel_mask == 8'd0)
        else $error("driver reset word with lines still active");

endmodule

bind led_matrix_row_refresh_core lmr_checker u_lmr_checker (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for led_matrix_row_refresh_core
// predicts every serial word and channel update from a model of the frame store and line mask
// depends on lmr_pkg and led_matrix_row_refresh_core
module tb_top;
    import lmr_pkg::*;

    localparam int unsigned N_ROWS        = ROWS_DEF;
    localparam int unsigned N_COLS        = COLS_DEF;
    localparam int unsigned WORDS_PER_COL = N_ROWS * 3;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned TAIL_CYCLES   = 4 * N_ROWS + 40;
    localparam longint unsigned RUN_LIMIT = 64'd8_000_000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    led_matrix_row_refresh_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // predicted copy of the block state
    logic [7:0] pixel_levels [0:N_COLS*N_ROWS*3-1];
    logic [7:0] line_mask;
    logic       colour_bank;

    t_out        expected_words[$];
    int unsigned error_count = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        holding     = 1'b0;
    event        hold_go;

    task automatic predict_command(input t_in cmd);
        t_out        w;
        int unsigned base;
        case (t_op'(cmd.opcode))
            OP_SET: begin
                if (cmd.column_index < N_COLS && cmd.row_index < N_ROWS) begin
                    base = (cmd.column_index * N_ROWS + cmd.row_index) * 3;
                    pixel_levels[base]     = cmd.blue_level;
                    pixel_levels[base + 1] = cmd.green_level;
                    pixel_levels[base + 2] = cmd.red_level;
                end
            end
            OP_REFRESH: begin
                if (cmd.column_index < N_COLS) begin
                    colour_bank = BANK_COLOUR;
                    base = cmd.column_index * WORDS_PER_COL;
                    for (int i = 0; i < WORDS_PER_COL; i++) begin
                        w              = '0;
                        w.result_kind  = KIND_WORD;
                        w.shift_word   = pixel_levels[base + i];
                        w.word_length  = LEN_COLOUR;
                        w.bank_select  = BANK_COLOUR;
                        w.latch_after  = (i == WORDS_PER_COL - 1);
                        w.channel_mask = line_mask;
                        w.last_of_run  = (i == WORDS_PER_COL - 1);
                        expected_words.push_back(w);
                    end
                end
            end
            OP_SELECT: begin
                if (cmd.column_index <= LINE_MAX && cmd.column_index < N_COLS) begin
                    line_mask = 8'(1 << cmd.column_index);
                end else begin
                    line_mask = '0;
                end
                w              = '0;
                w.result_kind  = KIND_CHAN;
                w.word_length  = LEN_NONE;
                w.bank_select  = colour_bank;
                w.channel_mask = line_mask;
                w.last_of_run  = 1'b1;
                expected_words.push_back(w);
            end
            default: begin
                line_mask = '0;
                for (int i = 0; i < WORDS_PER_COL; i++) begin
                    w              = '0;
                    w.result_kind  = KIND_WORD;
                    w.shift_word   = BRIGHT_WORD;
                    w.word_length  = LEN_BRIGHT;
                    w.bank_select  = BANK_BRIGHT;
                    w.channel_mask = line_mask;
                    w.reset_pulse  = (i == 0);
                    w.last_of_run  = (i == WORDS_PER_COL - 1);
                    expected_words.push_back(w);
                end
                colour_bank = BANK_COLOUR;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic check_word(input t_out got);
        t_out want;
        if (expected_words.size() == 0) begin
            $error("unexpected word %p", got);
            error_count++;
        end else begin
            want = expected_words.pop_front();
            compare_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
            compare_field("shift_word", want.shift_word, got.shift_word);
            compare_field("word_length", 8'(want.word_length), 8'(got.word_length));
            compare_field("bank_select", 8'(want.bank_select), 8'(got.bank_select));
            compare_field("latch_after", 8'(want.latch_after), 8'(got.latch_after));
            compare_field("channel_mask", want.channel_mask, got.channel_mask);
            compare_field("reset_pulse", 8'(want.reset_pulse), 8'(got.reset_pulse));
            compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        end
    endtask

    // output side: check taken words, then pick the stall for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_word(o_out_data);
        end
        i_out_stall <= holding || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off, counted here
    initial forever begin
        @(hold_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    // called at a rising edge; leaves valid high until the next word or stop_sending
    task automatic send_command(input t_in cmd);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        predict_command(cmd);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    function automatic t_in make_command(input t_op op, input logic [7:0] col,
                                         input logic [2:0] row, input logic [7:0] red,
                                         input logic [7:0] green, input logic [7:0] blue);
        t_in cmd;
        cmd.opcode       = op;
        cmd.column_index = col;
        cmd.row_index    = row;
        cmd.red_level    = red;
        cmd.green_level  = green;
        cmd.blue_level   = blue;
        return cmd;
    endfunction

    function automatic t_in random_command();
        t_in         cmd;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            cmd.opcode = OP_SET;
        end else if (pick < 75) begin
            cmd.opcode = OP_REFRESH;
        end else if (pick < 90) begin
            cmd.opcode = OP_SELECT;
        end else begin
            cmd.opcode = OP_INIT;
        end
        // mostly valid columns, now and then anything
        if ($urandom_range(9) == 0) begin
            cmd.column_index = 8'($urandom_range(255));
        end else begin
            cmd.column_index = 8'($urandom_range(N_COLS - 1));
        end
        cmd.row_index   = 3'($urandom_range(7));
        cmd.red_level   = 8'($urandom_range(255));
        cmd.green_level = 8'($urandom_range(255));
        cmd.blue_level  = 8'($urandom_range(255));
        return cmd;
    endfunction

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        // channel update before any refresh shows the brightness bank
        send_command(make_command(OP_SELECT, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd3, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_SET, 8'd0, 3'd0, 8'hFF, 8'h00, 8'hAA));
        send_command(make_command(OP_SET, 8'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_SET, 8'd7, 3'd0, 8'h00, 8'h80, 8'h01));
        send_command(make_command(OP_SET, 8'd0, 3'd5, 8'h55, 8'hAA, 8'h7F));
        // out-of-range columns leave the frame alone
        send_command(make_command(OP_SET, 8'd8, 3'd2, 8'h12, 8'h34, 8'h56));
        send_command(make_command(OP_SET, 8'd255, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_REFRESH, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd7, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd8, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd255, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_SELECT, 8'd7, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd8, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_SELECT, 8'd8, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_SELECT, 8'd255, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_SELECT, 8'd4, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_INIT, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_SELECT, 8'd3, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_REFRESH, 8'd7, 3'd0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(OP_INIT, 8'd255, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_REFRESH, 8'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        stop_sending();
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned n_cmds, input int unsigned idle,
                                       input int unsigned stall);
        t_in         cmd;
        int unsigned counted;
        idle_pct  = idle;
        stall_pct = stall;
        counted   = 0;
        while (counted < n_cmds) begin
            cmd = random_command();
            send_command(cmd);
            // ignored pixel writes and refreshes do not count
            if (!((cmd.opcode == OP_SET || cmd.opcode == OP_REFRESH)
                  && cmd.column_index >= N_COLS)) begin
                counted++;
            end
        end
        stop_sending();
        wait_drain();
    endtask

    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_go;
        // keep offering words so the core fills up and stalls its input
        repeat (16) send_command(random_command());
        stop_sending();
        wait_drain();
    endtask

    initial begin
        foreach (pixel_levels[i]) pixel_levels[i] = '0;
        line_mask   = '0;
        colour_bank = BANK_BRIGHT;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(70, 0, 0);
        test_random_traffic(70, 70, 0);
        test_random_traffic(70, 0, 70);
        test_random_traffic(70, 10, 10);
        test_output_hold();
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

endmodule
